// ----- rtl/gedr_pkg.sv -----
// Shared types, constants and tables for the gyro/encoder dead-reckoning block.
package gedr_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_COUNTS_PER_TURN   = 2'd0;
  localparam logic [1:0] REG_HEADING_SCALE     = 2'd1;
  localparam logic [1:0] REG_DRIFT_COEFFICIENT = 2'd2;

  localparam logic [31:0] CPT_RESET   = 32'd1;
  localparam logic [31:0] SCALE_RESET = 32'd65536;

  // CORDIC start value, gain compensated, Q30
  localparam logic signed [33:0] CORDIC_GAIN = 34'sh26DD3B6A;

  // Largest speed value
  localparam logic [40:0] SPEED_MAX = {41{1'b1}};

  // atan(2^-i) as binary angle
  localparam logic [31:0] ATAN_TAB [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic signed [47:0] gyro_count;
    logic signed [31:0] encoder_distance;
  } in_item_t;

  typedef struct packed {
    logic signed [39:0] pos_x;
    logic signed [39:0] pos_y;
    logic signed [31:0] heading;
    logic        [40:0] speed;
    logic               speed_valid;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV, ST_FIX, ST_HMUL, ST_MID, ST_DMUL, ST_STEP, ST_CORDIC,
    ST_SMUL, ST_CMUL, ST_YUPD, ST_SCALE, ST_SQ, ST_SQRT_GO, ST_SQRT, ST_DONE
  } state_t;

endpackage

// ----- rtl/gedr_if.sv -----
// Valid/ready channels for input ticks and result items.
interface gedr_in_if
  import gedr_pkg::*;
  ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

interface gedr_out_if
  import gedr_pkg::*;
  ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ----- rtl/gedr_mul.sv -----
// Shared signed 34x34 multiplier with registered product.
module gedr_mul
  import gedr_pkg::*;
(
  input  logic               clk,
  input  logic signed [33:0] a,
  input  logic signed [33:0] b,
  output logic signed [67:0] prod
);
  always_ff @(posedge clk) begin
    prod <= a * b;
  end
endmodule

// ----- rtl/gedr_div.sv -----
// Restoring remainder unit: one dividend bit per cycle.
module gedr_div
  import gedr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [47:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] rem
);
  logic [47:0] dvd;
  logic [31:0] dvs;
  logic [5:0]  cnt;
  logic        busy;
  logic [32:0] trial;

  assign trial = {rem, dvd[47]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd47) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // shift-subtract datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[46:0], 1'b0};
      if (trial >= {1'b0, dvs}) rem <= 32'(trial - {1'b0, dvs});
      else                      rem <= trial[31:0];
    end
  end
endmodule

// ----- rtl/gedr_cordic.sv -----
// Iterative rotation CORDIC: sin and cos of a binary angle in Q30.
module gedr_cordic
  import gedr_pkg::*;
#(
  parameter int CORDIC_STEPS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [31:0]        angle,
  output logic               done,
  output logic signed [33:0] sn,
  output logic signed [33:0] cs
);
  logic signed [33:0] x, y, z, xs, ys, at;
  logic [4:0] idx;
  logic       busy, flip;

  assign xs = x >>> idx;
  assign ys = y >>> idx;
  assign at = $signed({2'b00, ATAN_TAB[idx]});
  assign sn = flip ? -y : y;
  assign cs = flip ? -x : x;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      idx  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (busy) begin
        idx <= idx + 5'd1;
        if (idx == 5'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // fold into [-90,90) degrees, then rotate toward z = 0
  always_ff @(posedge clk) begin
    if (start) begin
      flip <= angle[31] ^ angle[30];
      z    <= (angle[31] ^ angle[30]) ? 34'($signed({~angle[31], angle[30:0]}))
                                      : 34'($signed(angle));
      x    <= CORDIC_GAIN;
      y    <= '0;
    end else if (busy) begin
      if (!z[33]) begin
        x <= x - ys; y <= y + xs; z <= z - at;
      end else begin
        x <= x + ys; y <= y - xs; z <= z + at;
      end
    end
  end
endmodule

// ----- rtl/gedr_sqrt.sv -----
// Digit-by-digit integer square root, two radicand bits per cycle.
module gedr_sqrt
  import gedr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [97:0] radicand,
  output logic        done,
  output logic [48:0] root
);
  logic [97:0] rad;
  logic [50:0] rem, cur, trial;
  logic [5:0]  cnt;
  logic        busy;

  assign cur   = {rem[48:0], rad[97:96]};
  assign trial = {root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd48) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // restoring root recurrence
  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad <= {rad[95:0], 2'b00};
      if (cur >= trial) begin
        rem  <= cur - trial;
        root <= {root[47:0], 1'b1};
      end else begin
        rem  <= cur;
        root <= {root[47:0], 1'b0};
      end
    end
  end
endmodule

// ----- rtl/gyro_encoder_dead_reckoning.sv -----
// Top level: sequencer and datapath for gyro/encoder dead reckoning.
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+-----------------------------------------
//  in_ch    | in  | valid/ready   | gyro_count, encoder_distance
//  out_ch   | out | valid/ready   | pos_x, pos_y, heading, speed, speed_valid
//  cfg      | in  | cfg_we        | cfg_index, cfg_wdata
//
// One item at a time: each item runs the remainder loop and the CORDIC
// iterations; a window-closing tick adds the squares on the shared
// multiplier and the square root. Synchronous active-high reset restores the
// configuration registers and clears the control state and accumulators,
// but not the datapath registers. in_ch is ready only when idle; a stalled
// result holds the sequencer in its final state until out_ch takes it.
module gyro_encoder_dead_reckoning
  import gedr_pkg::*;
#(
  parameter int WINDOW_TICKS = 10,
  parameter int CORDIC_STEPS = 24
) (
  input  logic        clk,
  input  logic        rst,
  gedr_in_if.sink     in_ch,
  gedr_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  localparam int PW = $clog2(WINDOW_TICKS);

  state_t state, state_next;

  logic [31:0] counts_per_turn, heading_scale, drift_coefficient, cpt_eff;
  logic [31:0] prev_heading, prev_encoder, enc_reg, rem_fix, cur, mid;
  logic        gyro_neg, closing;
  logic signed [32:0] delta;
  logic signed [33:0] step;
  logic signed [39:0] x_acc, y_acc, window_x, window_y;
  logic [PW-1:0] tick_phase;
  logic [47:0] ux, uy, gmag;
  logic [97:0] sq_acc;
  logic [2:0]  sq_k;
  logic [40:0] speed_r;

  logic signed [33:0] mul_a, mul_b, sn, cs;
  logic signed [67:0] prod;
  logic        div_start, div_done, cordic_start, cordic_done, sqrt_start, sqrt_done;
  logic [31:0] div_rem;
  logic [48:0] root;
  logic        accept, out_free;

  logic [31:0] head_w, hdiff, enc_d;
  logic signed [41:0] x_sum, y_sum;
  logic signed [39:0] x_sat, y_sat;
  logic signed [40:0] dx, dy;
  logic [40:0] ax, ay;
  logic [23:0] xh, xl, yh, yl;
  logic [97:0] sq_term;

  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = (state == ST_IDLE);
  assign cpt_eff     = (counts_per_turn == 32'd0) ? 32'd1 : counts_per_turn;
  assign gmag        = in_ch.data.gyro_count[47] ? 48'(-in_ch.data.gyro_count)
                                                 : 48'(in_ch.data.gyro_count);

  gedr_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod));

  gedr_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(gmag),
    .divisor(cpt_eff), .done(div_done), .rem(div_rem)
  );

  gedr_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst(rst), .start(cordic_start), .angle(mid),
    .done(cordic_done), .sn(sn), .cs(cs)
  );

  gedr_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sqrt_start), .radicand(sq_acc),
    .done(sqrt_done), .root(root)
  );

  // heading from the product, midpoint and encoder delta
  assign head_w = prod[47:16];
  assign hdiff  = head_w - prev_heading;
  assign enc_d  = enc_reg - prev_encoder;

  // position update with clamp
  assign x_sum = 42'(x_acc) - 42'($signed(prod[67:30]));
  assign y_sum = 42'(y_acc) + 42'($signed(prod[67:30]));
  assign x_sat = (x_sum > 42'sh7FFFFFFFFF) ? 40'sh7FFFFFFFFF :
                 (x_sum < -42'sh8000000000) ? -40'sh8000000000 : x_sum[39:0];
  assign y_sat = (y_sum > 42'sh7FFFFFFFFF) ? 40'sh7FFFFFFFFF :
                 (y_sum < -42'sh8000000000) ? -40'sh8000000000 : y_sum[39:0];

  // window distance magnitudes
  assign dx = 41'(x_acc) - 41'(window_x);
  assign dy = 41'(y_acc) - 41'(window_y);
  assign ax = dx[40] ? 41'(-dx) : 41'(dx);
  assign ay = dy[40] ? 41'(-dy) : 41'(dy);
  assign xh = ux[47:24];
  assign xl = ux[23:0];
  assign yh = uy[47:24];
  assign yl = uy[23:0];

  // place the previous partial product
  always_comb begin
    unique case (sq_k)
      3'd1, 3'd4: sq_term = 98'(prod[47:0]) << 48;
      3'd2, 3'd5: sq_term = 98'(prod[47:0]) << 25;
      default:    sq_term = 98'(prod[47:0]);
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (accept) state_next = ST_DIV;
      ST_DIV:     if (div_done) state_next = ST_FIX;
      ST_FIX:     state_next = ST_HMUL;
      ST_HMUL:    state_next = ST_MID;
      ST_MID:     state_next = ST_DMUL;
      ST_DMUL:    state_next = ST_STEP;
      ST_STEP:    state_next = ST_CORDIC;
      ST_CORDIC:  if (cordic_done) state_next = ST_SMUL;
      ST_SMUL:    state_next = ST_CMUL;
      ST_CMUL:    state_next = ST_YUPD;
      ST_YUPD:    state_next = (tick_phase >= PW'(WINDOW_TICKS - 1)) ? ST_SCALE : ST_DONE;
      ST_SCALE:   state_next = ST_SQ;
      ST_SQ:      if (sq_k == 3'd6) state_next = ST_SQRT_GO;
      ST_SQRT_GO: state_next = ST_SQRT;
      ST_SQRT:    if (sqrt_done) state_next = ST_DONE;
      ST_DONE:    if (out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // unit controls and multiplier operands
  always_comb begin
    div_start    = accept;
    cordic_start = (state == ST_STEP);
    sqrt_start   = (state == ST_SQRT_GO);
    mul_a        = '0;
    mul_b        = '0;
    unique case (state)
      ST_HMUL: begin
        mul_a = $signed({2'b00, rem_fix});
        mul_b = $signed({2'b00, heading_scale});
      end
      ST_DMUL: begin
        mul_a = 34'($signed(drift_coefficient));
        mul_b = 34'($signed(mid));
      end
      ST_SMUL: begin mul_a = step; mul_b = sn; end
      ST_CMUL: begin mul_a = step; mul_b = cs; end
      ST_SQ: begin
        unique case (sq_k)
          3'd0:    begin mul_a = $signed({10'd0, xh}); mul_b = $signed({10'd0, xh}); end
          3'd1:    begin mul_a = $signed({10'd0, xh}); mul_b = $signed({10'd0, xl}); end
          3'd2:    begin mul_a = $signed({10'd0, xl}); mul_b = $signed({10'd0, xl}); end
          3'd3:    begin mul_a = $signed({10'd0, yh}); mul_b = $signed({10'd0, yh}); end
          3'd4:    begin mul_a = $signed({10'd0, yh}); mul_b = $signed({10'd0, yl}); end
          3'd5:    begin mul_a = $signed({10'd0, yl}); mul_b = $signed({10'd0, yl}); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      default: ;
    endcase
  end

  // control state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      counts_per_turn   <= CPT_RESET;
      heading_scale     <= SCALE_RESET;
      drift_coefficient <= '0;
      prev_heading      <= '0;
      prev_encoder      <= '0;
      x_acc             <= '0;
      y_acc             <= '0;
      window_x          <= '0;
      window_y          <= '0;
      tick_phase        <= '0;
      out_ch.valid      <= 1'b0;
      sq_k              <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_COUNTS_PER_TURN:   counts_per_turn   <= cfg_wdata;
          REG_HEADING_SCALE:     heading_scale     <= cfg_wdata;
          REG_DRIFT_COEFFICIENT: drift_coefficient <= cfg_wdata;
          default: ;
        endcase
      end
      // a result loaded in ST_DONE replaces the one taken at this edge
      if (out_ch.valid && out_ch.ready && state != ST_DONE) out_ch.valid <= 1'b0;
      unique case (state)
        ST_CMUL: x_acc <= x_sat;
        ST_YUPD: begin
          y_acc        <= y_sat;
          prev_heading <= cur;
          prev_encoder <= enc_reg;
          if (tick_phase == '0) begin
            window_x <= x_acc;
            window_y <= y_sat;
          end
          if (tick_phase >= PW'(WINDOW_TICKS - 1)) tick_phase <= '0;
          else                                    tick_phase <= tick_phase + 1'b1;
        end
        ST_SCALE: sq_k <= '0;
        ST_SQ:    sq_k <= sq_k + 3'd1;
        ST_DONE:  if (out_free) out_ch.valid <= 1'b1;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      gyro_neg <= in_ch.data.gyro_count[47];
      enc_reg  <= in_ch.data.encoder_distance;
    end
    unique case (state)
      ST_FIX:   rem_fix <= (gyro_neg && div_rem != 32'd0) ? cpt_eff - div_rem : div_rem;
      ST_MID: begin
        cur   <= head_w;
        mid   <= prev_heading + {hdiff[31], hdiff[31:1]};
        delta <= $signed({enc_d[31], enc_d});
      end
      ST_STEP:  step <= 34'(delta) - 34'($signed(prod[63:32]));
      ST_YUPD: begin
        closing <= (tick_phase >= PW'(WINDOW_TICKS - 1));
        speed_r <= '0;
      end
      ST_SCALE: begin
        ux     <= 48'({ax, 6'd0}) + 48'({ax, 5'd0}) + 48'({ax, 2'd0});
        uy     <= 48'({ay, 6'd0}) + 48'({ay, 5'd0}) + 48'({ay, 2'd0});
        sq_acc <= '0;
      end
      ST_SQ:    if (sq_k != 3'd0) sq_acc <= sq_acc + sq_term;
      ST_SQRT:  if (sqrt_done) speed_r <= (root > 49'(SPEED_MAX)) ? SPEED_MAX : root[40:0];
      ST_DONE: begin
        if (out_free) begin
          out_ch.data.pos_x       <= x_acc;
          out_ch.data.pos_y       <= y_acc;
          out_ch.data.heading     <= cur;
          out_ch.data.speed       <= speed_r;
          out_ch.data.speed_valid <= closing;
        end
      end
      default: ;
    endcase
  end
endmodule

// ----- rtl/gedr_checker.sv -----
// Port-level checks for the dead-reckoning block, bound to the top level.
module gedr_port_checks
  import gedr_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);
  // one item at a time: busy right after an accepted item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready right after an accepted item");

  // speed is zero outside a closing tick
  a_speed_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.speed_valid) |-> (out_data.speed == '0))
    else $error("speed nonzero with speed_valid low");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result changed while stalled");

  // no result right out of reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");
endmodule

bind gyro_encoder_dead_reckoning gedr_port_checks u_gedr_port_checks (
  .clk(clk),
  .rst(rst),
  .in_valid(in_ch.valid),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_data(out_ch.data)
);
